// ===== hw/rtl/fph_pkg.sv =====
package fph_pkg;

  // Table geometry
  localparam int NUM_HOLES = 16;
  localparam int SIZE_BITS = 32;
  localparam int HOLE_W    = $clog2(NUM_HOLES);
  localparam int CNT_W     = $clog2(NUM_HOLES + 1);

  // Field widths fixed by the interface
  localparam int AMOUNT_W  = 32;
  localparam int SLOT_W    = 4;
  localparam int LEFT_W    = 32;
  localparam int HOLES_W   = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLES    = 1'b1;
  localparam logic [HOLES_W-1:0]   HOLES_RST    = 5'd16;

  // Placement policies
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_NEXT  = 2'd1;
  localparam logic [1:0] MODE_BEST  = 2'd2;
  localparam logic [1:0] MODE_WORST = 2'd3;

  // Item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_LOADED  = 2'd0;
  localparam logic [1:0] STAT_ALLOC   = 2'd1;
  localparam logic [1:0] STAT_NOALLOC = 2'd2;

  typedef struct packed {
    logic                action;
    logic [SLOT_W-1:0]   hole_slot;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] chosen_hole;
    logic [LEFT_W-1:0] space_left;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic issue;
    logic finish;
  } fph_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic more;
    logic out_free;
  } fph_stat_t;

endpackage

// ===== hw/rtl/fph_ram.sv =====
module fph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fph_ctrl.sv =====
module fph_ctrl import fph_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_alloc_i,
  output logic      in_stall_o,
  input  fph_stat_t stat_i,
  output fph_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  // Sequence one transaction: accept, scan the holes for an allocate, write back
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_stall_o    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = (in_alloc_i == ACT_ALLOC) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        // the last read is compared in the cycle after its issue
        if (stat_i.more) begin
          cmd_o.issue = 1'b1;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/fph_dp.sv =====
module fph_dp import fph_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  fph_cmd_t              cmd_i,
  output fph_stat_t             stat_o
);

  // Configuration
  logic [1:0]         fit_mode_q;
  logic [HOLES_W-1:0] holes_q;

  // Transaction and scan state
  in_item_t           item_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   issued_q;
  logic [HOLE_W-1:0]  addr_q;
  logic               rd_vld_q;
  logic [HOLE_W-1:0]  rd_idx_q;
  logic               pick_vld_q;
  logic [HOLE_W-1:0]  pick_idx_q;
  logic [SIZE_BITS-1:0] pick_size_q;
  logic [HOLE_W-1:0]  rover_q;
  logic [NUM_HOLES-1:0] hv_q;
  out_item_t          out_q;
  logic               out_vld_q;

  logic [CNT_W-1:0]     cnt_sat;
  logic [HOLE_W-1:0]    start_addr;
  logic [HOLE_W-1:0]    addr_next;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic [SIZE_BITS-1:0] scan_size;
  logic [SIZE_BITS-1:0] req_size;
  logic [SIZE_BITS-1:0] alloc_left;
  logic                 take;
  logic                 slot_ok;
  logic                 wr_en;
  logic [HOLE_W-1:0]    wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  out_item_t            result;

  // Hole count, scan start and next read address
  always_comb begin
    if (CNT_W'(holes_q) > CNT_W'(NUM_HOLES)) begin
      cnt_sat = CNT_W'(NUM_HOLES);
    end else begin
      cnt_sat = CNT_W'(holes_q);
    end
    start_addr = '0;
    if (fit_mode_q == MODE_NEXT && CNT_W'(rover_q) < cnt_sat) begin
      start_addr = rover_q;
    end
    if (CNT_W'(addr_q) == cnt_q - CNT_W'(1)) begin
      addr_next = '0;
    end else begin
      addr_next = addr_q + HOLE_W'(1);
    end
  end

  // Compare the hole just read against the current pick
  always_comb begin
    req_size  = SIZE_BITS'(item_q.amount);
    scan_size = hv_q[rd_idx_q] ? ram_rdata : '0;
    take      = 1'b0;
    if (rd_vld_q && scan_size >= req_size) begin
      case (fit_mode_q)
        MODE_BEST:  take = !pick_vld_q || (scan_size < pick_size_q);
        MODE_WORST: take = !pick_vld_q || (scan_size > pick_size_q);
        default:    take = !pick_vld_q;
      endcase
    end
  end

  // Write back and build the result
  always_comb begin
    alloc_left = pick_size_q - req_size;
    slot_ok    = CNT_W'(item_q.hole_slot) < CNT_W'(NUM_HOLES);
    wr_en      = 1'b0;
    wr_addr    = pick_idx_q;
    wr_data    = alloc_left;
    result     = '0;
    if (item_q.action == ACT_LOAD) begin
      wr_en              = slot_ok;
      wr_addr            = HOLE_W'(item_q.hole_slot);
      wr_data            = req_size;
      result.status      = STAT_LOADED;
      result.chosen_hole = item_q.hole_slot;
      result.space_left  = slot_ok ? LEFT_W'(req_size) : '0;
    end else if (pick_vld_q) begin
      wr_en              = 1'b1;
      result.status      = STAT_ALLOC;
      result.chosen_hole = SLOT_W'(pick_idx_q);
      result.space_left  = LEFT_W'(alloc_left);
    end else begin
      result.status      = STAT_NOALLOC;
    end
  end

  fph_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(NUM_HOLES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.finish && wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (cmd_i.issue),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= MODE_FIRST;
      holes_q    <= HOLES_RST;
      cnt_q      <= '0;
      issued_q   <= '0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      pick_vld_q <= 1'b0;
      rover_q    <= '0;
      hv_q       <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIT_MODE: fit_mode_q <= cfg_data_i[1:0];
          CFG_HOLES:    holes_q    <= cfg_data_i[HOLES_W-1:0];
          default:      ;
        endcase
      end
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.capture) begin
        cnt_q      <= cnt_sat;
        issued_q   <= '0;
        addr_q     <= start_addr;
        pick_vld_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          issued_q <= issued_q + CNT_W'(1);
          addr_q   <= addr_next;
        end
        if (take) begin
          pick_vld_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        if (wr_en) begin
          hv_q[wr_addr] <= 1'b1;
        end
        if (item_q.action == ACT_LOAD) begin
          rover_q <= '0;
        end else if (pick_vld_q && fit_mode_q == MODE_NEXT) begin
          rover_q <= pick_idx_q;
        end
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmd_i.issue) begin
      rd_idx_q <= addr_q;
    end
    if (take) begin
      pick_idx_q  <= rd_idx_q;
      pick_size_q <= scan_size;
    end
    if (cmd_i.finish) begin
      out_q <= result;
    end
  end

  assign stat_o.more     = issued_q < cnt_q;
  assign stat_o.out_free = !out_vld_q || !out_stall_i;
  assign out_valid_o     = out_vld_q;
  assign out_item_o      = out_q;

  // A picked hole always lies inside the searched range
  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_vld_q |-> CNT_W'(pick_idx_q) < cnt_q)
    else $error("picked hole outside the searched range");

  // The scan never reads more holes than are in use
  a_issued_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issued_q <= cnt_q)
    else $error("scan issued more reads than holes in use");

  // Every read address lies below the hole count
  a_addr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> CNT_W'(addr_q) < cnt_q)
    else $error("scan read outside the searched range");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_vld_q || !out_stall_i))
    else $error("result register overwritten while stalled");

endmodule

// ===== hw/rtl/fit_policy_hole_allocator.sv =====
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_item_i   (action, hole_slot, amount)
// out       output     out_valid_o / out_stall_i out_item_o  (status, chosen_hole, space_left)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A load transaction goes from accept straight to write back; an allocate first scans
// the holes in use with the single comparator that walks the hole table
// one RAM read per cycle.
// Reset clears the table through per-hole valid bits at once; no clearing pass.
// The result register lets a new transaction start while the last result is
// stalled; write back waits only when that register is still full.
module fit_policy_hole_allocator import fph_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  fph_cmd_t  cmd;
  fph_stat_t stat;

  fph_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_alloc_i(in_item_i.action),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  fph_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule
